// ===== hdl/pex_pkg.sv =====
// Package for the execute-stage ALU: field positions, opcode and function codes.
// No dependencies; used by pex_alu and pipeline_execute_stage_alu.
`default_nettype none

package pex_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned OpW     = 6;
  localparam int unsigned FuncW   = 6;
  localparam int unsigned ShamtW  = 5;
  localparam int unsigned ImmW    = 16;

  localparam int unsigned OpcodePos = 26;
  localparam int unsigned ShamtPos  = 6;

  typedef logic [DataW-1:0] data_t;
  typedef logic [OpW-1:0]   opcode_t;
  typedef logic [FuncW-1:0] func_t;
  typedef logic [ShamtW-1:0] shamt_t;

  // opcodes
  localparam opcode_t OP_RTYPE = 6'd0;
  localparam opcode_t OP_ADDI  = 6'd1;
  localparam opcode_t OP_ANDI  = 6'd2;
  localparam opcode_t OP_ORI   = 6'd3;
  localparam opcode_t OP_BR0   = 6'd4;
  localparam opcode_t OP_BR1   = 6'd5;
  localparam opcode_t OP_LOAD  = 6'd7;
  localparam opcode_t OP_STORE = 6'd8;
  localparam opcode_t OP_SUBI  = 6'd9;

  // register-type function codes
  localparam func_t FN_ADD  = 6'd0;
  localparam func_t FN_SUB  = 6'd1;
  localparam func_t FN_AND  = 6'd2;
  localparam func_t FN_OR   = 6'd3;
  localparam func_t FN_NOR  = 6'd4;
  localparam func_t FN_NAND = 6'd5;
  localparam func_t FN_SRL  = 6'd6;
  localparam func_t FN_SLL  = 6'd7;
  localparam func_t FN_JR   = 6'd8;
  localparam func_t FN_SGT  = 6'd9;
  localparam func_t FN_SLT  = 6'd10;

  function automatic data_t sext_imm(input data_t insn);
    sext_imm = {{(DataW-ImmW){insn[ImmW-1]}}, insn[ImmW-1:0]};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/pex_alu.sv =====
// Combinational ALU of the execute stage: decodes the instruction and forms the result.
// Depends on pex_pkg.
`default_nettype none

module pex_alu (
  input  wire pex_pkg::data_t instruction,
  input  wire pex_pkg::data_t operand_first,
  input  wire pex_pkg::data_t operand_second,
  input  wire pex_pkg::data_t operand_third,
  output pex_pkg::data_t      result
);

  pex_pkg::opcode_t opcode;
  pex_pkg::func_t   func;
  pex_pkg::shamt_t  shamt;
  pex_pkg::data_t   imm;
  pex_pkg::data_t   reg_res;

  assign opcode = instruction[pex_pkg::OpcodePos +: pex_pkg::OpW];
  assign func   = instruction[pex_pkg::FuncW-1:0];
  assign shamt  = instruction[pex_pkg::ShamtPos +: pex_pkg::ShamtW];
  assign imm    = pex_pkg::sext_imm(instruction);

  always_comb begin
    case (func)
      pex_pkg::FN_ADD:  reg_res = operand_second + operand_third;
      pex_pkg::FN_SUB:  reg_res = operand_second - operand_third;
      pex_pkg::FN_AND:  reg_res = operand_second & operand_third;
      pex_pkg::FN_OR:   reg_res = operand_second | operand_third;
      pex_pkg::FN_NOR:  reg_res = ~(operand_second | operand_third);
      pex_pkg::FN_NAND: reg_res = ~(operand_second & operand_third);
      pex_pkg::FN_SRL:  reg_res = operand_second >> shamt;
      pex_pkg::FN_SLL:  reg_res = operand_second << shamt;
      pex_pkg::FN_JR:   reg_res = operand_first;
      pex_pkg::FN_SGT:  reg_res = {{(pex_pkg::DataW-1){1'b0}},
                                   ($signed(operand_second) > $signed(operand_third))};
      pex_pkg::FN_SLT:  reg_res = {{(pex_pkg::DataW-1){1'b0}},
                                   ($signed(operand_second) < $signed(operand_third))};
      default:          reg_res = '0;
    endcase
  end

  always_comb begin
    case (opcode)
      pex_pkg::OP_RTYPE: result = reg_res;
      pex_pkg::OP_ADDI,
      pex_pkg::OP_LOAD,
      pex_pkg::OP_STORE: result = operand_second + imm;
      pex_pkg::OP_ANDI:  result = operand_second & imm;
      pex_pkg::OP_ORI:   result = operand_second | imm;
      pex_pkg::OP_BR0,
      pex_pkg::OP_BR1:   result = operand_first - operand_second;
      pex_pkg::OP_SUBI:  result = operand_second - imm;
      // jumps, exit and unknown opcodes pass the base through
      default:           result = operand_second;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/pipeline_execute_stage_alu.sv =====
// Top level of the execute-stage ALU: input register, ALU, result register.
// Depends on pex_pkg and pex_alu.
//
// Usage:
//   Input channel in_valid/in_ready carries one request: in_instruction and
//   three operands. Result channel out_valid/out_ready carries out_result.
//   A request accepted at one clock edge is registered in the input register,
//   passes the ALU and lands in the result register as soon as that register
//   is empty or being emptied; out_valid rises when it lands.
//   Throughput is one request per cycle while out_ready is not held low; both
//   register stages move together whenever the one after them is empty or being emptied.
//   When the receiver holds out_ready low, the result register holds, the
//   input register fills, and in_ready then drops; no request is lost or
//   repeated. Up to two requests are held inside.
//   Synchronous active-low reset (rst_n) empties both stages; the block is
//   ready for a request as soon as reset is released.
`default_nettype none

module pipeline_execute_stage_alu (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire pex_pkg::data_t in_instruction,
  input  wire pex_pkg::data_t in_operand_first,
  input  wire pex_pkg::data_t in_operand_second,
  input  wire pex_pkg::data_t in_operand_third,
  output logic                out_valid,
  input  wire                 out_ready,
  output pex_pkg::data_t      out_result
);

  logic           s1_valid_r;
  pex_pkg::data_t insn_r;
  pex_pkg::data_t op_first_r;
  pex_pkg::data_t op_second_r;
  pex_pkg::data_t op_third_r;
  logic           out_valid_r;
  pex_pkg::data_t result_r;
  pex_pkg::data_t result_nxt;
  logic           s2_free;

  assign s2_free  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s2_free;

  pex_alu u_alu (
    .instruction    (insn_r),
    .operand_first  (op_first_r),
    .operand_second (op_second_r),
    .operand_third  (op_third_r),
    .result         (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_free) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      insn_r      <= in_instruction;
      op_first_r  <= in_operand_first;
      op_second_r <= in_operand_second;
      op_third_r  <= in_operand_third;
    end
    if (s2_free && s1_valid_r) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = result_r;

endmodule

`default_nettype wire

// ===== dv/tb_pipeline_execute_stage_alu.sv =====
// Self-checking testbench for pipeline_execute_stage_alu: directed and random requests
// under four handshake pressure settings, each result checked against an in-bench predictor.
// Depends on pex_pkg and the RTL of pipeline_execute_stage_alu.
module tb_pipeline_execute_stage_alu;

  // opcodes the package does not name
  localparam pex_pkg::opcode_t OP_JUMP = 6'd6;
  localparam pex_pkg::opcode_t OP_JAL  = 6'd10;
  localparam pex_pkg::opcode_t OP_EXIT = 6'd11;

  localparam int IdleLimit = 2000;
  localparam int RandPerPhase = 125;
  localparam int NumPhases = 4;

  typedef struct packed {
    pex_pkg::data_t insn;
    pex_pkg::data_t first;
    pex_pkg::data_t second;
    pex_pkg::data_t third;
  } request_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  pex_pkg::data_t in_instruction = '0;
  pex_pkg::data_t in_operand_first = '0;
  pex_pkg::data_t in_operand_second = '0;
  pex_pkg::data_t in_operand_third = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  pex_pkg::data_t out_result;

  request_t       pend_q[$];
  pex_pkg::data_t result_q[$];
  request_t       next_req;
  pex_pkg::data_t want;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_fail = 0;
  int idle_cycles = 0;

  pipeline_execute_stage_alu u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_instruction    (in_instruction),
    .in_operand_first  (in_operand_first),
    .in_operand_second (in_operand_second),
    .in_operand_third  (in_operand_third),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result        (out_result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic pex_pkg::data_t exec_result(pex_pkg::data_t insn,
                                                 pex_pkg::data_t first,
                                                 pex_pkg::data_t second,
                                                 pex_pkg::data_t third);
    pex_pkg::opcode_t op;
    pex_pkg::func_t   fn;
    pex_pkg::shamt_t  sh;
    pex_pkg::data_t   imm;
    op  = insn[pex_pkg::OpcodePos +: pex_pkg::OpW];
    fn  = insn[pex_pkg::FuncW-1:0];
    sh  = insn[pex_pkg::ShamtPos +: pex_pkg::ShamtW];
    imm = {{(pex_pkg::DataW-pex_pkg::ImmW){insn[pex_pkg::ImmW-1]}},
           insn[pex_pkg::ImmW-1:0]};
    case (op)
      pex_pkg::OP_RTYPE: begin
        case (fn)
          pex_pkg::FN_ADD:  return second + third;
          pex_pkg::FN_SUB:  return second - third;
          pex_pkg::FN_AND:  return second & third;
          pex_pkg::FN_OR:   return second | third;
          pex_pkg::FN_NOR:  return ~(second | third);
          pex_pkg::FN_NAND: return ~(second & third);
          pex_pkg::FN_SRL:  return second >> sh;
          pex_pkg::FN_SLL:  return second << sh;
          pex_pkg::FN_JR:   return first;
          pex_pkg::FN_SGT:  return pex_pkg::data_t'($signed(second) > $signed(third));
          pex_pkg::FN_SLT:  return pex_pkg::data_t'($signed(second) < $signed(third));
          default: return '0;
        endcase
      end
      pex_pkg::OP_ADDI, pex_pkg::OP_LOAD, pex_pkg::OP_STORE: return second + imm;
      pex_pkg::OP_ANDI: return second & imm;
      pex_pkg::OP_ORI:  return second | imm;
      pex_pkg::OP_BR0, pex_pkg::OP_BR1: return first - second;
      pex_pkg::OP_SUBI: return second - imm;
      default: return second;
    endcase
  endfunction

  function automatic pex_pkg::data_t rtype_word(pex_pkg::func_t fn, pex_pkg::shamt_t sh);
    return {pex_pkg::OP_RTYPE, 15'($urandom), sh, fn};
  endfunction

  function automatic pex_pkg::data_t imm_word(pex_pkg::opcode_t op,
                                              logic [pex_pkg::ImmW-1:0] imm);
    return {op, 10'($urandom), imm};
  endfunction

  // biased towards the values where carries and signs turn over
  function automatic pex_pkg::data_t rand_operand();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_req(pex_pkg::data_t insn, pex_pkg::data_t first,
                          pex_pkg::data_t second, pex_pkg::data_t third);
    pend_q.push_back('{insn, first, second, third});
  endtask

  task automatic push_directed();
    push_req(rtype_word(pex_pkg::FN_ADD, '0), $urandom, '1, 32'd1);
    push_req(rtype_word(pex_pkg::FN_SUB, '0), $urandom, '0, 32'd1);
    push_req(rtype_word(pex_pkg::FN_AND, '0), $urandom, '1, 32'h8000_0000);
    push_req(rtype_word(pex_pkg::FN_OR, '0), $urandom, '0, '0);
    push_req(rtype_word(pex_pkg::FN_NOR, '0), $urandom, '0, '0);
    push_req(rtype_word(pex_pkg::FN_NAND, '0), $urandom, '1, '1);
    push_req(rtype_word(pex_pkg::FN_SRL, '1), $urandom, 32'h8000_0000, $urandom);
    push_req(rtype_word(pex_pkg::FN_SRL, '0), $urandom, '1, $urandom);
    push_req(rtype_word(pex_pkg::FN_SLL, '1), $urandom, 32'd1, $urandom);
    push_req(rtype_word(pex_pkg::FN_JR, '0), '1, $urandom, $urandom);
    push_req(rtype_word(pex_pkg::FN_SGT, '0), $urandom, 32'h7fff_ffff, 32'h8000_0000);
    push_req(rtype_word(pex_pkg::FN_SLT, '0), $urandom, 32'h7fff_ffff, 32'h8000_0000);
    push_req(rtype_word('1, '1), '1, '1, '1);  // unknown function code
    push_req(imm_word(pex_pkg::OP_ADDI, 16'h8000), $urandom, '0, $urandom);
    push_req(imm_word(pex_pkg::OP_ANDI, 16'h7fff), $urandom, '1, $urandom);
    push_req(imm_word(pex_pkg::OP_ORI, 16'hffff), $urandom, '0, $urandom);
    push_req(imm_word(pex_pkg::OP_BR0, 16'($urandom)), '0, 32'd1, $urandom);
    push_req(imm_word(pex_pkg::OP_BR1, 16'($urandom)), 32'h8000_0000, 32'h7fff_ffff,
             $urandom);
    push_req(imm_word(OP_JUMP, 16'($urandom)), $urandom, $urandom, $urandom);
    push_req(imm_word(pex_pkg::OP_LOAD, 16'hffff), $urandom, '0, $urandom);
    push_req(imm_word(pex_pkg::OP_STORE, 16'h0000), $urandom, '1, $urandom);
    push_req(imm_word(pex_pkg::OP_SUBI, 16'h8000), $urandom, 32'h7fff_ffff, $urandom);
    push_req(imm_word(OP_JAL, 16'($urandom)), $urandom, $urandom, $urandom);
    push_req(imm_word(OP_EXIT, 16'($urandom)), $urandom, $urandom, $urandom);
    push_req(imm_word('1, 16'($urandom)), '1, '1, '1);  // unknown opcode
  endtask

  task automatic push_random(int count);
    pex_pkg::data_t insn;
    pex_pkg::data_t second;
    pex_pkg::data_t third;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: insn = rtype_word(
            pex_pkg::func_t'($urandom_range(pex_pkg::FN_ADD, pex_pkg::FN_SLT)),
            5'($urandom));
        4: insn = rtype_word(
            pex_pkg::func_t'($urandom_range(pex_pkg::FN_SLT + 1,
                                            (1 << pex_pkg::FuncW) - 1)),
            5'($urandom));
        5, 6, 7: insn = imm_word(
            pex_pkg::opcode_t'($urandom_range(pex_pkg::OP_ADDI, OP_EXIT)),
            16'($urandom));
        8: insn = imm_word(
            pex_pkg::opcode_t'($urandom_range(OP_EXIT + 1, (1 << pex_pkg::OpW) - 1)),
            16'($urandom));
        default: insn = $urandom;
      endcase
      second = rand_operand();
      third = ($urandom_range(0, 9) == 0) ? second : rand_operand();
      push_req(insn, rand_operand(), second, third);
    end
  endtask

  // driver: expectation recorded when a request is presented, order is kept
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pend_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        next_req = pend_q.pop_front();
        result_q.push_back(exec_result(next_req.insn, next_req.first, next_req.second,
                                       next_req.third));
        in_valid          <= 1'b1;
        in_instruction    <= next_req.insn;
        in_operand_first  <= next_req.first;
        in_operand_second <= next_req.second;
        in_operand_third  <= next_req.third;
        n_sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (out_valid && out_ready) begin
        n_checked++;
        if (result_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("unexpected result %08h with nothing outstanding", out_result);
        end else begin
          want = result_q.pop_front();
          if (out_result !== want) begin
            n_fail++;
            if (n_fail <= 10)
              $display("result mismatch: expected %08h, got %08h", want, out_result);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no handshake for %0d cycles", IdleLimit);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    int send_pct[NumPhases];
    int recv_pct[NumPhases];
    send_pct = '{0, 81, 0, 21};
    recv_pct = '{0, 0, 81, 21};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < NumPhases; ph++) begin
      @(negedge clk);
      send_idle_pct = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      if (ph == 0)
        push_directed();
      push_random(RandPerPhase);
      while (pend_q.size() != 0 || in_valid || result_q.size() != 0)
        @(negedge clk);
    end
    repeat (8) @(posedge clk);
    $display("%0d requests sent, %0d results checked, over four stall/idle settings",
             n_sent, n_checked);
    if (n_fail == 0 && result_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", n_fail, result_q.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/pex_pkg.sv
hdl/pex_alu.sv
hdl/pipeline_execute_stage_alu.sv
dv/tb_pipeline_execute_stage_alu.sv
